/* design/huf_pkg.sv */
// huf_pkg: shared types and codes for the huffman stream decoder
// holds the item and result structs, action and status codes, fsm states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package huf_pkg;

    localparam int SYM_W = 7;

    typedef logic [1:0] t_action;
    typedef logic [1:0] t_status;

    localparam t_action ACT_CLEAR  = 2'd0;
    localparam t_action ACT_LOAD   = 2'd1;
    localparam t_action ACT_DECODE = 2'd2;

    localparam t_status ST_SYMBOL  = 2'd0;
    localparam t_status ST_LOADED  = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_MISSING = 2'd3;

    typedef struct packed {
        t_action            action;
        logic [SYM_W-1:0]   symbol_in;
        logic [31:0]        code_bits;
        logic [5:0]         code_length;
        logic [7:0]         data_byte;
        logic [3:0]         valid_bits;
    } t_item;

    typedef struct packed {
        logic [SYM_W-1:0]   out_symbol;
        t_status            status;
        logic               last_of_run;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_LOAD_FIN,
        S_DECODE,
        S_FLUSH
    } t_state;

endpackage

`default_nettype wire

/* design/huffman_stream_decoder.sv */
// Huffman stream decoder. An item is taken when start is high and busy is low.
// A clear gives no result. A load walks one code bit per cycle through the node
// memory, then writes the leaf in S_LOAD_FIN and sends the result from S_FLUSH
// (a zero length or a full node store goes straight to S_FLUSH). A decode walks
// one bit per cycle, pauses for the read on each leaf it reaches and once more
// when the byte ends inside the tree, and sends its last result from S_FLUSH.
// The registered read of the node memory sets the one-bit-per-cycle walk.
// Results come one per cycle on o_result with o_result_valid high for that cycle;
// the receiver cannot stall them. The root node lives in registers, so no
// clearing pass is needed.
// depends on huf_pkg and huf_node_store
`timescale 1ns / 1ps
`default_nettype none

module huffman_stream_decoder #(
    parameter int SYMBOL_COUNT = 128,
    parameter int MAX_CODE_LEN = 32,
    parameter int NODE_DEPTH   = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire huf_pkg::t_item   i_item,
    output logic                  busy,
    output logic                  o_result_valid,
    output huf_pkg::t_result      o_result
);
    import huf_pkg::*;

    localparam int AW = $clog2(NODE_DEPTH);
    localparam int CW = $clog2(NODE_DEPTH + 1);
    localparam int LW = 2 + 2 * AW;

    typedef struct packed {
        logic [1:0]    present;
        logic [AW-1:0] left;
        logic [AW-1:0] right;
    } t_link;

    t_state           r_state, n_state;
    logic [1:0]       r_root_pres, n_root_pres;
    logic [AW-1:0]    r_root_left, n_root_left;
    logic [AW-1:0]    r_root_right, n_root_right;
    logic [CW-1:0]    r_nodes, n_nodes;
    logic [AW-1:0]    r_pos, n_pos;
    logic             r_pend, n_pend;
    logic             r_hold_vld, n_hold_vld;
    logic             r_out_vld, n_out_vld;
    t_result          r_hold, n_hold;
    t_result          r_out, n_out;
    logic [AW-1:0]    r_cur, n_cur;
    logic             r_fresh, n_fresh;
    logic [5:0]       r_cnt, n_cnt;
    logic [31:0]      r_code, n_code;
    logic [SYM_W-1:0] r_sym, n_sym;
    logic [7:0]       r_byte, n_byte;
    logic [AW-1:0]    r_child, n_child;

    // node store port signals
    logic             link_we;
    logic [AW-1:0]    link_waddr;
    t_link            link_wdata;
    logic             sym_we;
    logic [AW-1:0]    sym_waddr;
    logic [SYM_W-1:0] sym_wdata;
    logic [AW-1:0]    rd_addr;
    logic [LW-1:0]    link_rdata;
    logic [SYM_W-1:0] sym_rdata;

    t_link            q_e;
    t_link            root_e;
    t_link            ld_e;
    t_link            upd_e;
    t_link            dc_e;
    logic             ld_bit;
    logic [5:0]       ld_pos;
    logic [AW-1:0]    fresh_idx;
    logic             dc_eval;
    logic             dc_bit;
    logic [AW-1:0]    dc_next;
    logic             ld_done;
    logic             ld_full;
    logic             dc_end;
    logic             res_gen;
    t_result          res;
    logic [5:0]       len_eff;
    logic [5:0]       vb_eff;
    logic [SYM_W-1:0] sym_red;

    huf_node_store #(
        .NODE_DEPTH (NODE_DEPTH),
        .AW         (AW),
        .LW         (LW)
    ) u_store (
        .i_clk        (i_clk),
        .i_link_we    (link_we),
        .i_link_waddr (link_waddr),
        .i_link_wdata (link_wdata),
        .i_sym_we     (sym_we),
        .i_sym_waddr  (sym_waddr),
        .i_sym_wdata  (sym_wdata),
        .i_raddr      (rd_addr),
        .o_link_rdata (link_rdata),
        .o_sym_rdata  (sym_rdata)
    );

    assign q_e    = t_link'(link_rdata);
    assign root_e = '{present: r_root_pres, left: r_root_left, right: r_root_right};

    // item field preparation
    always_comb begin
        logic [15:0] v;
        v = {9'd0, i_item.symbol_in};
        // remainder by restoring compare-subtract, seven narrow steps
        for (int k = 6; k >= 0; k--) begin
            if (v >= (16'(SYMBOL_COUNT) << k)) begin
                v = v - (16'(SYMBOL_COUNT) << k);
            end
        end
        sym_red = v[SYM_W-1:0];
        if ({1'b0, i_item.code_length} > 7'(MAX_CODE_LEN)) begin
            len_eff = 6'(MAX_CODE_LEN);
        end else begin
            len_eff = i_item.code_length;
        end
        if (i_item.valid_bits > 4'd8) begin
            vb_eff = 6'd8;
        end else begin
            vb_eff = {2'd0, i_item.valid_bits};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_item.action == ACT_LOAD) begin
                    n_state = (len_eff == 6'd0) ? S_FLUSH : S_LOAD;
                end else if (start && i_item.action == ACT_DECODE && vb_eff != 6'd0) begin
                    n_state = S_DECODE;
                end
            end
            S_LOAD: begin
                if (ld_full) begin
                    n_state = S_FLUSH;
                end else if (ld_done) begin
                    n_state = S_LOAD_FIN;
                end
            end
            S_LOAD_FIN: n_state = S_FLUSH;
            S_DECODE: begin
                if (dc_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        busy           = (r_state != S_IDLE);
        o_result_valid = r_out_vld;
        o_result       = r_out;
    end

    // datapath and memory control
    always_comb begin
        n_root_pres  = r_root_pres;
        n_root_left  = r_root_left;
        n_root_right = r_root_right;
        n_nodes      = r_nodes;
        n_pos        = r_pos;
        n_pend       = r_pend;
        n_hold_vld   = r_hold_vld;
        n_hold       = r_hold;
        n_out_vld    = 1'b0;
        n_out        = r_out;
        n_cur        = r_cur;
        n_fresh      = r_fresh;
        n_cnt        = r_cnt;
        n_code       = r_code;
        n_sym        = r_sym;
        n_byte       = r_byte;
        n_child      = r_child;

        link_we    = 1'b0;
        link_waddr = r_cur;
        link_wdata = '0;
        sym_we     = 1'b0;
        sym_waddr  = r_cur;
        sym_wdata  = r_sym;
        rd_addr    = r_pos;

        ld_done   = 1'b0;
        ld_full   = 1'b0;
        dc_end    = 1'b0;
        res_gen   = 1'b0;
        res       = '{out_symbol: '0, status: ST_SYMBOL, last_of_run: 1'b0};

        // load walk: current entry is zero for a node allocated on this walk
        ld_pos = r_cnt - 6'd1;
        ld_bit = ld_pos[5] ? 1'b0 : r_code[ld_pos[4:0]];
        if (r_fresh) begin
            ld_e = '0;
        end else if (r_cur == '0) begin
            ld_e = root_e;
        end else begin
            ld_e = q_e;
        end
        fresh_idx = r_nodes[AW-1:0];
        upd_e     = ld_e;
        if (ld_bit) begin
            upd_e.present[1] = 1'b1;
            upd_e.right      = fresh_idx;
        end else begin
            upd_e.present[0] = 1'b1;
            upd_e.left       = fresh_idx;
        end

        dc_eval = 1'b0;
        dc_e    = (r_pos == '0) ? root_e : q_e;
        dc_bit  = r_byte[7];
        dc_next = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_item.action)
                        ACT_CLEAR: begin
                            n_root_pres = 2'b00;
                            n_nodes     = CW'(1);
                            n_pos       = '0;
                        end
                        ACT_LOAD: begin
                            n_code  = i_item.code_bits;
                            n_sym   = sym_red;
                            n_cur   = '0;
                            n_fresh = 1'b0;
                            n_cnt   = len_eff;
                            if (len_eff == 6'd0) begin
                                res_gen    = 1'b1;
                                res.status = ST_LOADED;
                            end
                        end
                        ACT_DECODE: begin
                            n_byte = i_item.data_byte;
                            n_cnt  = vb_eff;
                            n_pend = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (ld_e.present[ld_bit]) begin
                    n_cur   = ld_bit ? ld_e.right : ld_e.left;
                    n_fresh = 1'b0;
                    rd_addr = n_cur;
                end else if (r_nodes == CW'(NODE_DEPTH)) begin
                    ld_full    = 1'b1;
                    res_gen    = 1'b1;
                    res.status = ST_FULL;
                    // a node allocated earlier on this walk still needs its links cleared
                    link_we    = r_fresh;
                end else begin
                    if (r_cur == '0) begin
                        n_root_pres  = upd_e.present;
                        n_root_left  = upd_e.left;
                        n_root_right = upd_e.right;
                    end else begin
                        link_we    = 1'b1;
                        link_wdata = upd_e;
                    end
                    sym_we    = 1'b1;
                    sym_waddr = fresh_idx;
                    sym_wdata = '0;
                    n_nodes   = r_nodes + CW'(1);
                    n_cur     = fresh_idx;
                    n_fresh   = 1'b1;
                end
                if (!ld_full) begin
                    n_cnt = r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        ld_done = 1'b1;
                    end
                end
            end
            S_LOAD_FIN: begin
                link_we    = r_fresh;
                sym_we     = (r_cur != '0);
                res_gen    = 1'b1;
                res.status = ST_LOADED;
            end
            S_DECODE: begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    if (q_e.present == 2'b00) begin
                        res_gen        = 1'b1;
                        res.out_symbol = sym_rdata;
                        res.status     = ST_SYMBOL;
                        n_pos          = '0;
                        dc_end         = (r_cnt == 6'd0);
                    end else begin
                        n_pos   = r_child;
                        dc_e    = q_e;
                        dc_eval = (r_cnt != 6'd0);
                        dc_end  = (r_cnt == 6'd0);
                    end
                end else begin
                    dc_eval = 1'b1;
                end
                if (dc_eval) begin
                    if (!dc_e.present[dc_bit]) begin
                        res_gen    = 1'b1;
                        res.status = ST_MISSING;
                        n_pos      = '0;
                        dc_end     = 1'b1;
                    end else begin
                        dc_next = dc_bit ? dc_e.right : dc_e.left;
                        rd_addr = dc_next;
                        n_child = dc_next;
                        n_pend  = 1'b1;
                        n_cnt   = r_cnt - 6'd1;
                        n_byte  = {r_byte[6:0], 1'b0};
                    end
                end
            end
            S_FLUSH: begin
                if (r_hold_vld) begin
                    n_out             = r_hold;
                    n_out.last_of_run = 1'b1;
                    n_out_vld         = 1'b1;
                    n_hold_vld        = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // a new result pushes the held one out; it was not the last of the item
        if (res_gen) begin
            if (r_hold_vld) begin
                n_out             = r_hold;
                n_out.last_of_run = 1'b0;
                n_out_vld         = 1'b1;
            end
            n_hold     = res;
            n_hold_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root_pres <= 2'b00;
            r_nodes     <= CW'(1);
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_hold_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root_pres <= n_root_pres;
            r_nodes     <= n_nodes;
            r_pos       <= n_pos;
            r_pend      <= n_pend;
            r_hold_vld  <= n_hold_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root_left  <= n_root_left;
        r_root_right <= n_root_right;
        r_hold       <= n_hold;
        r_out        <= n_out;
        r_cur        <= n_cur;
        r_fresh      <= n_fresh;
        r_cnt        <= n_cnt;
        r_code       <= n_code;
        r_sym        <= n_sym;
        r_byte       <= n_byte;
        r_child      <= n_child;
    end

endmodule

`default_nettype wire

/* design/huf_node_store.sv */
// huf_node_store: node link memory and leaf symbol memory of the code tree
// one write port per memory, one shared read address, registered read data
// depends on huf_pkg
`timescale 1ns / 1ps
`default_nettype none

module huf_node_store #(
    parameter int NODE_DEPTH = 256,
    parameter int AW         = 8,
    parameter int LW         = 18
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_link_we,
    input  wire logic [AW-1:0]           i_link_waddr,
    input  wire logic [LW-1:0]           i_link_wdata,
    input  wire logic                    i_sym_we,
    input  wire logic [AW-1:0]           i_sym_waddr,
    input  wire logic [huf_pkg::SYM_W-1:0] i_sym_wdata,
    input  wire logic [AW-1:0]           i_raddr,
    output logic      [LW-1:0]           o_link_rdata,
    output logic      [huf_pkg::SYM_W-1:0] o_sym_rdata
);
    import huf_pkg::*;

    logic [LW-1:0]    r_link_mem [NODE_DEPTH];
    logic [SYM_W-1:0] r_sym_mem  [NODE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            r_link_mem[i_link_waddr] <= i_link_wdata;
        end
        o_link_rdata <= r_link_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_sym_we) begin
            r_sym_mem[i_sym_waddr] <= i_sym_wdata;
        end
        o_sym_rdata <= r_sym_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* test/huf_decode_checker.sv */
// huf_decode_checker: watches the item and result channels of the huffman stream decoder
// keeps its own code tree and walk position, predicts each result and compares in order
// depends on huf_pkg
`timescale 1ns / 1ps

module huf_decode_checker #(
    parameter int SYMBOL_COUNT = 128,
    parameter int MAX_CODE_LEN = 32,
    parameter int NODE_DEPTH   = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  huf_pkg::t_item   i_item,
    input  logic             i_result_valid,
    input  huf_pkg::t_result i_result,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked,
    output int               o_symbols,
    output int               o_faults
);
    import huf_pkg::*;

    int         left_of  [NODE_DEPTH];
    int         right_of [NODE_DEPTH];
    logic [1:0] kids     [NODE_DEPTH];
    logic [6:0] sym_at   [NODE_DEPTH];
    int         nodes_used;
    int         walk_pos;
    t_result    results_due[$];
    int         mismatches;
    int         checked;
    int         symbols;
    int         faults;

    function automatic void clear_tree();
        foreach (kids[n]) kids[n] = 2'b00;
        sym_at[0]  = '0;
        nodes_used = 1;
        walk_pos   = 0;
    endfunction

    // appends one predicted result at the tail of the queue
    function automatic void queue_result(input t_result r);
        results_due.insert(results_due.size(), r);
    endfunction

    // advances the tree model by one accepted item and queues what it should produce
    function automatic void tree_step(input t_item it);
        t_result    r;
        int         len;
        int         cnt;
        int         cur;
        int         pos;
        int         first;
        logic       b;
        logic [1:0] m;
        bit         full;

        r = '0;
        case (it.action)
            ACT_CLEAR: begin
                clear_tree();
            end
            ACT_LOAD: begin
                len  = (it.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(it.code_length);
                cur  = 0;
                full = 1'b0;
                for (pos = len - 1; pos >= 0; pos--) begin
                    b = (pos < 32) ? it.code_bits[pos] : 1'b0;
                    m = b ? 2'b10 : 2'b01;
                    if ((kids[cur] & m) == 2'b00) begin
                        if (nodes_used >= NODE_DEPTH) begin
                            full = 1'b1;
                            break;
                        end
                        kids[nodes_used]   = 2'b00;
                        sym_at[nodes_used] = '0;
                        if (b) right_of[cur] = nodes_used;
                        else   left_of[cur]  = nodes_used;
                        kids[cur]  = kids[cur] | m;
                        nodes_used = nodes_used + 1;
                    end
                    cur = b ? right_of[cur] : left_of[cur];
                end
                if (!full) sym_at[cur] = 7'(int'(it.symbol_in) % SYMBOL_COUNT);
                r.status      = full ? ST_FULL : ST_LOADED;
                r.last_of_run = 1'b1;
                queue_result(r);
            end
            ACT_DECODE: begin
                cnt   = (it.valid_bits > 8) ? 8 : int'(it.valid_bits);
                first = results_due.size();
                for (pos = 0; pos < cnt; pos++) begin
                    b   = it.data_byte[7 - pos];
                    m   = b ? 2'b10 : 2'b01;
                    cur = walk_pos;
                    if ((kids[cur] & m) == 2'b00) begin
                        // dead end: report it and drop the rest of the byte
                        r.out_symbol = '0;
                        r.status     = ST_MISSING;
                        queue_result(r);
                        walk_pos = 0;
                        break;
                    end
                    cur = b ? right_of[cur] : left_of[cur];
                    if (kids[cur] == 2'b00) begin
                        r.out_symbol = sym_at[cur];
                        r.status     = ST_SYMBOL;
                        queue_result(r);
                        walk_pos = 0;
                    end else begin
                        walk_pos = cur;
                    end
                end
                if (results_due.size() > first) results_due[$].last_of_run = 1'b1;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input t_result want,
                                            input t_result got);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
            $display("%0t: %s: expected sym %0d status %0d last %0b, got sym %0d status %0d last %0b",
                     $realtime, what, want.out_symbol, want.status, want.last_of_run,
                     got.out_symbol, got.status, got.last_of_run);
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_tree();
            results_due.delete();
            mismatches = 0;
            checked    = 0;
            symbols    = 0;
            faults     = 0;
        end else begin
            // results first: a transfer at this edge belongs to an older item
            if (i_result_valid) begin
                checked = checked + 1;
                if (i_result.status == ST_SYMBOL) symbols = symbols + 1;
                if (i_result.status == ST_FULL || i_result.status == ST_MISSING)
                    faults = faults + 1;
                if (results_due.size() == 0) begin
                    report_mismatch("result with none pending", '0, i_result);
                end else begin
                    want = results_due.pop_front();
                    if (want.out_symbol !== i_result.out_symbol || want.status !== i_result.status
                            || want.last_of_run !== i_result.last_of_run)
                        report_mismatch("result mismatch", want, i_result);
                end
            end
            if (i_start && !i_busy) tree_step(i_item);
        end
        o_errors  <= mismatches;
        o_pending <= results_due.size();
        o_checked <= checked;
        o_symbols <= symbols;
        o_faults  <= faults;
    end

endmodule

/* test/huffman_stream_decoder_tb.sv */
// huffman_stream_decoder_tb: drives loads, clears and byte decodes into the decoder
// directed corner cases first, then random prefix-free code sets and encoded streams
// depends on huf_pkg, huffman_stream_decoder and huf_decode_checker
`timescale 1ns / 1ps

module huffman_stream_decoder_tb;
    import huf_pkg::*;

    localparam int      IDLE_LIMIT   = 2000;
    localparam int      ITEM_GOAL    = 380;
    localparam int      TAIL_CYCLES  = 40;
    localparam t_action ACT_UNUSED   = 2'd3;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    int errors;
    int pending;
    int checked;
    int symbols;
    int faults;
    int n_clear;
    int n_load;
    int n_decode;
    int n_ignored;
    int idle_cycles;
    bit gaps_on;

    huffman_stream_decoder #(
        .SYMBOL_COUNT(128),
        .MAX_CODE_LEN(32),
        .NODE_DEPTH  (256)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_item        (i_item),
        .busy          (busy),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    huf_decode_checker #(
        .SYMBOL_COUNT(128),
        .MAX_CODE_LEN(32),
        .NODE_DEPTH  (256)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_result_valid(o_result_valid),
        .i_result      (o_result),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_symbols     (symbols),
        .o_faults      (faults)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_item rand_item();
        t_item it;
        it.action      = t_action'($urandom_range(0, 3));
        it.symbol_in   = 7'($urandom);
        it.code_bits   = $urandom;
        it.code_length = 6'($urandom);
        it.data_byte   = 8'($urandom);
        it.valid_bits  = 4'($urandom);
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer or the gap
    task automatic send_item(input t_item it);
        int gap;
        start  = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        case (it.action)
            ACT_CLEAR:  n_clear++;
            ACT_LOAD:   n_load++;
            ACT_DECODE: if (it.valid_bits == 0) n_ignored++; else n_decode++;
            default:    n_ignored++;
        endcase
        if (gaps_on && $urandom_range(0, 1) == 0) begin
            gap    = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            start  = 1'b0;
            i_item = rand_item();
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_clear();
        t_item it;
        it        = rand_item();
        it.action = ACT_CLEAR;
        send_item(it);
    endtask

    task automatic send_load(input logic [6:0] sym, input logic [31:0] bits,
                             input logic [5:0] len);
        t_item it;
        it             = rand_item();
        it.action      = ACT_LOAD;
        it.symbol_in   = sym;
        it.code_bits   = bits;
        it.code_length = len;
        send_item(it);
    endtask

    task automatic send_decode(input logic [7:0] data, input logic [3:0] vb);
        t_item it;
        it            = rand_item();
        it.action     = ACT_DECODE;
        it.data_byte  = data;
        it.valid_bits = vb;
        send_item(it);
    endtask

    initial begin
        logic [31:0] cw_val[$];
        int          cw_len[$];
        logic        stream[$];
        logic [7:0]  data;
        t_item       it;
        int          goal;
        int          phase;
        int          leaves;
        int          rot;
        int          nsym;
        int          vb;
        int          k;
        int          j;
        int          b;
        int          r;

        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_item    = '0;
        n_clear   = 0;
        n_load    = 0;
        n_decode  = 0;
        n_ignored = 0;
        gaps_on   = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty tree: the first bit has nowhere to go
        send_decode(8'hFF, 4'd8);
        // zero-length code lands on the root, never emitted
        send_load(7'd99, 32'h0, 6'd0);
        send_load(7'd127, 32'b0, 6'd1);
        send_load(7'd0, 32'b10, 6'd2);
        send_load(7'd42, 32'b110, 6'd3);
        send_load(7'd85, 32'b111, 6'd3);
        // symbol on an interior node, must never come out
        send_load(7'd7, 32'b1, 6'd1);
        send_decode(8'h00, 4'd8);
        send_decode(8'hB7, 4'd15);
        // walk left mid-path, picked up by the next byte
        send_decode(8'hC0, 4'd1);
        send_decode(8'hC0, 4'd2);
        send_decode(8'h55, 4'd0);
        it        = rand_item();
        it.action = ACT_UNUSED;
        send_item(it);
        send_clear();
        send_load(7'd1, 32'b0, 6'd1);
        send_load(7'd2, 32'b10, 6'd2);
        // interior then missing child, tail of the byte dropped
        send_decode(8'hFF, 4'd8);
        // overlong length saturates
        send_load(7'd127, 32'hFFFF_FFFF, 6'd63);
        send_load(7'd0, 32'h0, 6'd32);
        send_decode(8'h00, 4'd8);
        // fill the node store with long codes until a load runs out of room
        send_clear();
        for (j = 0; j < 9; j++)
            send_load(7'(j), (32'(j) << 29) | ($urandom & 32'h1FFF_FFFF), 6'd32);
        send_decode(8'($urandom), 4'd8);

        goal  = ITEM_GOAL;
        phase = 0;
        while (n_clear + n_load + n_decode < goal) begin
            phase++;
            gaps_on = (phase % 3) != 1;
            if ($urandom_range(0, 4) != 0) send_clear();

            // random prefix-free code: split random leaves of a growing tree
            cw_val.delete();
            cw_len.delete();
            cw_val.insert(0, 32'h0);
            cw_len.insert(0, 0);
            leaves = $urandom_range(2, (phase % 4 == 0) ? 40 : 10);
            while (cw_val.size() < leaves) begin
                k = $urandom_range(0, cw_val.size() - 1);
                if (cw_len[k] < 24) begin
                    cw_val.insert(cw_val.size(), {cw_val[k][30:0], 1'b1});
                    cw_len.insert(cw_len.size(), cw_len[k] + 1);
                    cw_val[k] = {cw_val[k][30:0], 1'b0};
                    cw_len[k] = cw_len[k] + 1;
                end
            end

            rot = $urandom_range(0, cw_val.size() - 1);
            for (j = 0; j < cw_val.size(); j++) begin
                k = (j + rot) % cw_val.size();
                // now and then leave a hole so the stream runs into a missing child
                if ($urandom_range(0, 11) == 0) continue;
                send_load(7'($urandom_range(0, 127)), cw_val[k], 6'(cw_len[k]));
                if ($urandom_range(0, 15) == 0)
                    send_load(7'($urandom), $urandom, 6'($urandom_range(0, 63)));
            end

            stream.delete();
            nsym = $urandom_range(8, 40);
            repeat (nsym) begin
                k = $urandom_range(0, cw_val.size() - 1);
                for (b = cw_len[k] - 1; b >= 0; b--)
                    stream.insert(stream.size(), cw_val[k][b]);
            end
            // pack MSB first, last byte trimmed, pad bits random
            while (stream.size() > 0) begin
                data = 8'($urandom);
                vb   = 0;
                while (vb < 8 && stream.size() > 0) begin
                    data[7 - vb] = stream.pop_front();
                    vb++;
                end
                send_decode(data, 4'(vb));
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    send_decode(8'($urandom), 4'($urandom));
                end else if (r == 1) begin
                    it        = rand_item();
                    it.action = ACT_UNUSED;
                    send_item(it);
                end
            end
        end

        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("stimulus: %0d clears, %0d code loads, %0d byte decodes, %0d ignored items",
                 n_clear, n_load, n_decode, n_ignored);
        $display("checked %0d results: %0d decoded symbols, %0d tree-full or dead-end reports",
                 checked, symbols, faults);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
